// ===== sv/sbp_pkg.sv =====
// Shared types, constants and the coil table for the stepper bounce positioner.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package sbp_pkg;

  localparam int unsigned POS_BITS    = 13;
  localparam int unsigned COIL_PHASES = 4;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPWARD_POS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DOWN_POS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNCE_DIST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_ENABLE = 3'd4;

  localparam logic [15:0] STEP_DELAY_RST = 16'd1000;
  localparam logic [15:0] TICKS_MAX      = 16'hFFFF;
  localparam logic [1:0]  PHASE_LAST     = 2'(COIL_PHASES - 1);
  localparam logic [3:0]  COILS_OFF      = 4'b0000;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_GO_UP   = 2'd1,
    ACT_GO_DOWN = 2'd2,
    ACT_SET_POS = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    BNC_HI0 = 4'd0,
    BNC_HI1 = 4'd1,
    BNC_HI2 = 4'd2,
    BNC_HI3 = 4'd3,
    BNC_HI4 = 4'd4,
    BNC_LO0 = 4'd5,
    BNC_LO1 = 4'd6,
    BNC_LO2 = 4'd7,
    BNC_LO3 = 4'd8,
    BNC_LO4 = 4'd9
  } bnc_e;

  typedef struct packed {
    logic [15:0] delay_ticks;
    logic [11:0] upward_pos;
    logic [11:0] down_pos;
    logic [9:0]  bounce_dist;
    logic        step_enable;
  } cfg_t;

  typedef struct packed {
    logic [POS_BITS-1:0] current_pos;
    logic [POS_BITS-1:0] target_pos;
    logic                moving_up;
    logic [1:0]          coil_phase;
    logic                phase_ascending;
    bnc_e                bounce;
    logic [15:0]         elapsed;
    logic [3:0]          coil_drive;
  } state_t;

  typedef struct packed {
    logic [3:0]          coils;
    logic [POS_BITS-1:0] position;
    logic                stepped;
    logic                moving;
    logic [3:0]          bounce_phase;
  } result_t;

  function automatic logic [3:0] coil_pattern(input logic [1:0] phase);
    logic [3:0] pat;
    case (phase)
      2'd0:    pat = 4'b1001;
      2'd1:    pat = 4'b0101;
      2'd2:    pat = 4'b0110;
      2'd3:    pat = 4'b1010;
      default: pat = COILS_OFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sbp_cfg_regs.sv =====
// Configuration register file of the stepper bounce positioner.
// Depends on sbp_pkg for the register indexes and cfg_t.
`default_nettype none

module sbp_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output sbp_pkg::cfg_t                       cfg_o
);

  sbp_pkg::cfg_t cfg_q;
  sbp_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        sbp_pkg::CFG_STEP_DELAY:  cfg_d.delay_ticks = cfg_data_i;
        sbp_pkg::CFG_UPWARD_POS:  cfg_d.upward_pos  = cfg_data_i[11:0];
        sbp_pkg::CFG_DOWN_POS:    cfg_d.down_pos    = cfg_data_i[11:0];
        sbp_pkg::CFG_BOUNCE_DIST: cfg_d.bounce_dist = cfg_data_i[9:0];
        sbp_pkg::CFG_STEP_ENABLE: cfg_d.step_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.delay_ticks <= sbp_pkg::STEP_DELAY_RST;
      cfg_q.upward_pos  <= '0;
      cfg_q.down_pos    <= '0;
      cfg_q.bounce_dist <= '0;
      cfg_q.step_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/sbp_step_logic.sv =====
// Next-state and result logic for one beat: go commands, set position, tick
// timing, coil stepping and the bounce sequence. Depends on sbp_pkg.
`default_nettype none

module sbp_step_logic (
  input  wire sbp_pkg::cfg_t                  cfg_i,
  input  wire sbp_pkg::state_t                state_i,
  input  wire sbp_pkg::act_e                  action_i,
  input  wire logic [sbp_pkg::POS_BITS-1:0]   position_value_i,
  output sbp_pkg::state_t                     state_o,
  output sbp_pkg::result_t                    result_o
);

  localparam int unsigned PB = sbp_pkg::POS_BITS;

  always_comb begin
    sbp_pkg::state_t     st;
    logic [15:0]         ticks;
    logic                stepped;
    logic [PB-1:0]       p;
    logic [11:0]         dist3;
    logic [11:0]         dist3_rnd;
    logic [10:0]         dist15;
    logic [10:0]         dist2;

    st        = state_i;
    stepped   = 1'b0;
    ticks     = state_i.elapsed;
    p         = state_i.current_pos;
    dist3     = 12'(cfg_i.bounce_dist) + 12'({cfg_i.bounce_dist, 1'b0});
    dist3_rnd = dist3 + 12'd1;
    dist15    = dist3_rnd[11:1];
    dist2     = {cfg_i.bounce_dist, 1'b0};

    case (action_i)
      sbp_pkg::ACT_GO_UP: begin
        st.elapsed         = '0;
        st.target_pos      = PB'(cfg_i.upward_pos);
        st.moving_up       = 1'b1;
        st.coil_phase      = '0;
        st.phase_ascending = 1'b0;
        st.bounce          = sbp_pkg::BNC_HI0;
      end
      sbp_pkg::ACT_GO_DOWN: begin
        st.elapsed         = '0;
        st.target_pos      = PB'(cfg_i.down_pos);
        st.moving_up       = 1'b0;
        st.coil_phase      = sbp_pkg::PHASE_LAST;
        st.phase_ascending = 1'b1;
        st.bounce          = sbp_pkg::BNC_LO0;
      end
      sbp_pkg::ACT_SET_POS: begin
        st.current_pos = position_value_i;
      end
      default: begin
        if (cfg_i.step_enable && (state_i.target_pos != state_i.current_pos)) begin
          if (ticks != sbp_pkg::TICKS_MAX) begin
            ticks = ticks + 16'd1;
          end
          st.elapsed = ticks;
          if (ticks >= cfg_i.delay_ticks) begin
            st.elapsed    = '0;
            st.coil_drive = sbp_pkg::coil_pattern(state_i.coil_phase);
            if (state_i.phase_ascending) begin
              st.coil_phase = (state_i.coil_phase == sbp_pkg::PHASE_LAST) ? 2'd0
                            : state_i.coil_phase + 2'd1;
            end else begin
              st.coil_phase = (state_i.coil_phase == 2'd0) ? sbp_pkg::PHASE_LAST
                            : state_i.coil_phase - 2'd1;
            end
            p = state_i.moving_up ? state_i.current_pos + PB'(1)
                                  : state_i.current_pos - PB'(1);
            st.current_pos = p;
            stepped        = 1'b1;
            if (p == state_i.target_pos) begin
              case (state_i.bounce)
                sbp_pkg::BNC_HI0: begin
                  st.bounce          = sbp_pkg::BNC_HI1;
                  st.target_pos      = p - PB'(dist3);
                  st.moving_up       = 1'b0;
                  st.coil_phase      = sbp_pkg::PHASE_LAST;
                  st.phase_ascending = 1'b1;
                end
                sbp_pkg::BNC_HI1, sbp_pkg::BNC_HI3: begin
                  st.bounce          = (state_i.bounce == sbp_pkg::BNC_HI1)
                                     ? sbp_pkg::BNC_HI2 : sbp_pkg::BNC_HI4;
                  st.target_pos      = PB'(cfg_i.upward_pos);
                  st.moving_up       = 1'b1;
                  st.coil_phase      = '0;
                  st.phase_ascending = 1'b0;
                end
                sbp_pkg::BNC_HI2: begin
                  st.bounce          = sbp_pkg::BNC_HI3;
                  st.target_pos      = p - PB'(dist15);
                  st.moving_up       = 1'b0;
                  st.coil_phase      = sbp_pkg::PHASE_LAST;
                  st.phase_ascending = 1'b1;
                end
                sbp_pkg::BNC_LO0: begin
                  st.bounce          = sbp_pkg::BNC_LO1;
                  st.target_pos      = p + PB'(dist2);
                  st.moving_up       = 1'b1;
                  st.coil_phase      = '0;
                  st.phase_ascending = 1'b0;
                end
                sbp_pkg::BNC_LO1, sbp_pkg::BNC_LO3: begin
                  st.bounce          = (state_i.bounce == sbp_pkg::BNC_LO1)
                                     ? sbp_pkg::BNC_LO2 : sbp_pkg::BNC_LO4;
                  st.target_pos      = PB'(cfg_i.down_pos);
                  st.moving_up       = 1'b0;
                  st.coil_phase      = sbp_pkg::PHASE_LAST;
                  st.phase_ascending = 1'b1;
                end
                sbp_pkg::BNC_LO2: begin
                  st.bounce          = sbp_pkg::BNC_LO3;
                  st.target_pos      = p + PB'(cfg_i.bounce_dist);
                  st.moving_up       = 1'b1;
                  st.coil_phase      = '0;
                  st.phase_ascending = 1'b0;
                end
                sbp_pkg::BNC_HI4, sbp_pkg::BNC_LO4: begin
                  st.coil_drive = sbp_pkg::COILS_OFF;
                end
                default: ;
              endcase
            end
          end
        end
      end
    endcase

    state_o               = st;
    result_o.coils        = st.coil_drive;
    result_o.position     = st.current_pos;
    result_o.stepped      = stepped;
    result_o.moving       = (st.target_pos != st.current_pos);
    result_o.bounce_phase = st.bounce;
  end

endmodule

`default_nettype wire

// ===== sv/stepper_bounce_positioner_top.sv =====
// Stepper bounce positioner: an accepted input beat reaches its result beat on the
// output through the input register, then the result register. Throughput one beat
// per cycle unless the output stalls; the state update is one pass of step logic.
// Reset (rst_ni low, asynchronous): position and target 0, moving up, phase 0,
// bounce hi0, timer 0, coils off, step_delay 1000, other config registers 0.
// Depends on sbp_pkg, sbp_cfg_regs and sbp_step_logic.
`default_nettype none

module stepper_bounce_positioner_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sbp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic [1:0]                     action_i,
  input  wire logic [sbp_pkg::POS_BITS-1:0]   position_value_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic [3:0]                     coils_o,
  output      logic [sbp_pkg::POS_BITS-1:0]   position_o,
  output      logic                           stepped_o,
  output      logic                           moving_o,
  output      logic [3:0]                     bounce_phase_o
);

  sbp_pkg::cfg_t    cfg;
  sbp_pkg::state_t  st_q;
  sbp_pkg::state_t  st_d;
  sbp_pkg::result_t res_d;
  sbp_pkg::result_t res_q;

  logic                          s1_valid_q;
  sbp_pkg::act_e                 s1_action_q;
  logic [sbp_pkg::POS_BITS-1:0]  s1_pos_q;
  logic                          out_valid_q;
  logic                          advance;
  logic                          s1_fire;
  logic                          in_fire;

  sbp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sbp_step_logic u_step (
    .cfg_i            (cfg),
    .state_i          (st_q),
    .action_i         (s1_action_q),
    .position_value_i (s1_pos_q),
    .state_o          (st_d),
    .result_o         (res_d)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_action_q <= sbp_pkg::act_e'(action_i);
      s1_pos_q    <= position_value_i;
    end
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.current_pos     <= '0;
      st_q.target_pos      <= '0;
      st_q.moving_up       <= 1'b1;
      st_q.coil_phase      <= '0;
      st_q.phase_ascending <= 1'b0;
      st_q.bounce          <= sbp_pkg::BNC_HI0;
      st_q.elapsed         <= '0;
      st_q.coil_drive      <= sbp_pkg::COILS_OFF;
    end else if (s1_fire) begin
      st_q <= st_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign coils_o        = res_q.coils;
  assign position_o     = res_q.position;
  assign stepped_o      = res_q.stepped;
  assign moving_o       = res_q.moving;
  assign bounce_phase_o = res_q.bounce_phase;

`ifndef SYNTH
  a_step_moves_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && res_d.stepped |-> st_d.current_pos != st_q.current_pos)
    else $error("step beat left the position unchanged");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_valid_o)
    else $error("processed beat produced no result");

  a_coil_pattern_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(st_q.coil_drive) == 2 || st_q.coil_drive == sbp_pkg::COILS_OFF)
    else $error("illegal coil drive pattern");
`endif

endmodule

`default_nettype wire
